>>> src/imu_caf_pkg.sv
// shared types, constants and functions for the attitude filter
package imu_caf_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int TABLE_LEN           = 24;
  localparam int ANGLE_W             = 32;
  localparam int GYRO_DEN            = 131;

  localparam logic [2:0] REG_FILTER_MODE   = 3'd0;
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd1;
  localparam logic [2:0] REG_GYRO_WEIGHT   = 3'd2;

  localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd655;
  localparam logic [15:0] RST_GYRO_WEIGHT   = 16'd32113;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT_START,
    ST_ROOT,
    ST_CORDIC,
    ST_NEXT_TILT,
    ST_GYRO_MUL,
    ST_GYRO_DIV,
    ST_BLEND_A,
    ST_BLEND_B,
    ST_BLEND_C,
    ST_DONE
  } caf_state_t;

  // start strobe for an iterative unit
  typedef struct packed {
    logic start;
  } caf_ctl_t;

  // atan(2^-i) in degrees, Q24
  function automatic logic [31:0] atan_q24(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'd754974720;
      5'd1:  t = 32'd445687602;
      5'd2:  t = 32'd235489088;
      5'd3:  t = 32'd119537938;
      5'd4:  t = 32'd60000934;
      5'd5:  t = 32'd30029717;
      5'd6:  t = 32'd15018523;
      5'd7:  t = 32'd7509720;
      5'd8:  t = 32'd3754917;
      5'd9:  t = 32'd1877466;
      5'd10: t = 32'd938734;
      5'd11: t = 32'd469367;
      5'd12: t = 32'd234684;
      5'd13: t = 32'd117342;
      5'd14: t = 32'd58671;
      5'd15: t = 32'd29335;
      5'd16: t = 32'd14668;
      5'd17: t = 32'd7334;
      5'd18: t = 32'd3667;
      5'd19: t = 32'd1833;
      5'd20: t = 32'd917;
      5'd21: t = 32'd458;
      5'd22: t = 32'd229;
      5'd23: t = 32'd115;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

>>> src/imu_caf_isqrt.sv
// bit-serial integer square root, one result bit per cycle
module imu_caf_isqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  imu_caf_pkg::caf_ctl_t   ctl,
  input  logic [47:0]             radicand,
  output logic                    done,
  output logic [23:0]             root
);
  // 48-bit radicand, 24 result bits
  logic [47:0] rem_r, rem_nxt;
  logic [23:0] root_r, root_nxt;
  logic [47:0] src_r, src_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [49:0] trial;
  logic [49:0] rem_sh;

  always_comb begin
    rem_sh   = {rem_r, src_r[47:46]};
    trial    = rem_sh - {24'd0, root_r, 2'b01};
    rem_nxt  = rem_r;
    root_nxt = root_r;
    src_nxt  = src_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctl.start) begin
      rem_nxt  = '0;
      root_nxt = '0;
      src_nxt  = radicand;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      src_nxt = {src_r[45:0], 2'b00};
      if (!trial[49]) begin
        rem_nxt  = trial[47:0];
        root_nxt = {root_r[22:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[47:0];
        root_nxt = {root_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    src_r  <= src_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  assign done = busy_r && (cnt_r == 5'd23);
  assign root = root_nxt;
endmodule

>>> src/imu_caf_cordic.sv
// vectoring cordic, one rotation per cycle
module imu_caf_cordic #(
  parameter int ANGLE_FRAC_BITS = imu_caf_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = imu_caf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  imu_caf_pkg::caf_ctl_t ctl,
  input  logic signed [24:0]    y_in,
  input  logic [23:0]           x_in,
  output logic                  done,
  output logic signed [35:0]    angle
);
  localparam int STEPS = (CORDIC_STEPS < imu_caf_pkg::TABLE_LEN) ?
                         CORDIC_STEPS : imu_caf_pkg::TABLE_LEN;
  localparam int SH = 24 - ANGLE_FRAC_BITS;

  // x grows by at most 1.65, y stays within the start magnitude
  logic signed [27:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [35:0] z_r, z_nxt;
  logic [4:0]         i_r, i_nxt;
  logic               busy_r, busy_nxt;
  logic signed [27:0] xs, ys;
  logic [32:0]        t2;
  logic signed [35:0] a;
  logic               zero_r, zero_nxt;

  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    t2 = {imu_caf_pkg::atan_q24(i_r), 1'b0} >> SH;
    a  = signed'({3'b000, (t2 + 33'd1) >> 1});
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; zero_nxt = zero_r;
    if (ctl.start) begin
      x_nxt = signed'({4'd0, x_in});
      y_nxt = 28'(y_in);
      z_nxt = '0;
      i_nxt = '0;
      zero_nxt = (x_in == '0) && (y_in == '0);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!y_r[27]) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + a;
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - a;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(STEPS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; i_r <= i_nxt; zero_r <= zero_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  assign done  = busy_r && (i_r == 5'(STEPS - 1));
  assign angle = zero_r ? '0 : z_nxt;
endmodule

>>> src/imu_caf_divider.sv
// restoring divider by the constant gyro denominator, one quotient bit per cycle
module imu_caf_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  imu_caf_pkg::caf_ctl_t ctl,
  input  logic [63:0]           dividend,
  input  logic [31:0]           divisor,
  output logic                  done,
  output logic [63:0]           quotient
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] sh, df;

  always_comb begin
    sh = {rem_r[31:0], q_r[63]};
    df = sh - {1'b0, divisor};
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (ctl.start) begin
      q_nxt = dividend; rem_nxt = '0; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!df[32]) begin
        rem_nxt = df; q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh; q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  assign done     = busy_r && (cnt_r == 7'd63);
  assign quotient = q_nxt;
endmodule

>>> src/imu_complementary_attitude_filter.sv
// top level: complementary roll, pitch and yaw attitude filter
// a sample runs two tilt passes (root, then cordic) and, in gyro mode, three gyro passes (divide, then blend)
// accelerometer-only mode skips the three gyro passes
// a new sample is taken only once the last one is through, the root, cordic and divider used in turn
// a stalled result holds the block in its last state until the result register frees
// reset (synchronous, active low) clears the angle state and loads the register defaults
module imu_complementary_attitude_filter #(
  parameter int ANGLE_FRAC_BITS = imu_caf_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = imu_caf_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x_raw,
  input  logic signed [15:0] in_accel_y_raw,
  input  logic signed [15:0] in_accel_z_raw,
  input  logic signed [15:0] in_yaw_rate_raw,
  input  logic signed [15:0] in_roll_rate_raw,
  input  logic signed [15:0] in_pitch_rate_raw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_roll_deg,
  output logic signed [31:0] out_pitch_deg,
  output logic signed [31:0] out_yaw_deg,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  // configuration registers
  logic        mode_r;
  logic [15:0] period_r, weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b1;
      period_r <= imu_caf_pkg::RST_SAMPLE_PERIOD;
      weight_r <= imu_caf_pkg::RST_GYRO_WEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imu_caf_pkg::REG_FILTER_MODE:   mode_r   <= cfg_data[0];
        imu_caf_pkg::REG_SAMPLE_PERIOD: period_r <= cfg_data;
        imu_caf_pkg::REG_GYRO_WEIGHT:   weight_r <= cfg_data;
        default: ;
      endcase
    end
  end

  imu_caf_pkg::caf_state_t st_r, st_nxt;

  // captured sample
  logic signed [15:0] ax_r, ay_r, az_r, gz_r, gx_r, gy_r;
  logic               tilt_r, tilt_nxt;       // 0 roll tilt, 1 pitch tilt
  logic [1:0]         axis_r, axis_nxt;       // gyro axis: 0 roll, 1 pitch, 2 yaw
  logic signed [35:0] tilt_roll_r, tilt_pitch_r;
  logic signed [31:0] last_roll_r, last_pitch_r, last_yaw_r;
  logic signed [31:0] res_roll_r, res_pitch_r, res_yaw_r;
  logic               out_valid_r;
  logic signed [33:0] prop_r;                  // last + increment, unsaturated
  logic signed [33:0] inc_r;
  logic               neg_r;
  logic signed [51:0] prod_a_r, prod_b_r;
  logic signed [53:0] blend_sum;

  // tilt operands: the two squared axes under the root
  logic signed [15:0] sa, sb;
  logic [31:0]        sqa, sqb, sqsum;
  logic [47:0]        radicand;
  always_comb begin
    sa    = tilt_r ? ay_r : ax_r;
    sb    = az_r;
    sqa   = 32'(sa) * 32'(sa);
    sqb   = 32'(sb) * 32'(sb);
    sqsum = sqa + sqb;
    radicand = {sqsum, 16'd0};
  end

  // roll tilt: atan2(ay, sqrt(ax^2+az^2)); pitch: atan2(-ax, sqrt(ay^2+az^2))
  logic signed [24:0] cord_y;
  always_comb begin
    if (!tilt_r) cord_y = {ay_r[15], ay_r, 8'd0};
    else cord_y = -{ax_r[15], ax_r, 8'd0};
  end

  imu_caf_pkg::caf_ctl_t root_ctl, cord_ctl, div_ctl;
  logic        root_done, cord_done, div_done;
  logic [23:0] root_val;
  logic [23:0] root_hold_r;
  logic signed [35:0] cord_angle;
  logic [63:0] quot;

  imu_caf_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .ctl(root_ctl),
    .radicand(radicand), .done(root_done), .root(root_val)
  );

  imu_caf_cordic #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk(clk), .rst_n(rst_n), .ctl(cord_ctl),
    .y_in(cord_y), .x_in(root_hold_r), .done(cord_done), .angle(cord_angle)
  );

  localparam logic [31:0] DEN = 32'(imu_caf_pkg::GYRO_DEN * 65536);

  // gyro numerator magnitude: |raw| * period << frac, plus half the divisor
  logic signed [15:0] graw;
  logic [16:0]        gmag;
  logic [32:0]        gprod;
  logic [63:0]        gnum;
  always_comb begin
    unique case (axis_r)
      2'd0:    graw = gx_r;
      2'd1:    graw = gy_r;
      default: graw = gz_r;
    endcase
    gmag  = graw[15] ? 17'(-{graw[15], graw}) : {1'b0, graw};
    gprod = 33'(gmag) * 33'(period_r);
    gnum  = ({31'd0, gprod} << ANGLE_FRAC_BITS) + 64'(DEN >> 1);
  end

  // the divider loads the numerator straight from the gyro path at start
  imu_caf_divider u_div (
    .clk(clk), .rst_n(rst_n), .ctl(div_ctl),
    .dividend(gnum), .divisor(DEN), .done(div_done), .quotient(quot)
  );

  logic signed [31:0] last_sel;
  logic signed [35:0] acc_sel;
  logic [15:0]        w_eff;
  always_comb begin
    last_sel = axis_r == 2'd0 ? last_roll_r :
               axis_r == 2'd1 ? last_pitch_r : last_yaw_r;
    acc_sel  = axis_r == 2'd0 ? tilt_roll_r : tilt_pitch_r;
    w_eff    = weight_r > 16'd32768 ? 16'd32768 : weight_r;
  end

  function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
    if (v > 54'sd2147483647) return 32'sh7fffffff;
    if (v < -54'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // weighted sum of the products registered in the previous cycle
  logic signed [53:0] shifted;
  assign blend_sum = 54'(prod_a_r) + 54'(prod_b_r) + 54'sd16384;
  assign shifted   = blend_sum >>> 15;

  // sequencer
  always_comb begin
    st_nxt   = st_r;
    tilt_nxt = tilt_r;
    axis_nxt = axis_r;
    root_ctl.start = 1'b0;
    cord_ctl.start = 1'b0;
    div_ctl.start  = 1'b0;
    unique case (st_r)
      imu_caf_pkg::ST_IDLE:
        if (in_valid && in_ready) begin
          st_nxt = imu_caf_pkg::ST_ROOT_START;
          tilt_nxt = 1'b0;
        end
      imu_caf_pkg::ST_ROOT_START: begin
        root_ctl.start = 1'b1;
        st_nxt = imu_caf_pkg::ST_ROOT;
      end
      imu_caf_pkg::ST_ROOT:
        if (root_done) st_nxt = imu_caf_pkg::ST_NEXT_TILT;
      imu_caf_pkg::ST_NEXT_TILT: begin
        cord_ctl.start = 1'b1;
        st_nxt = imu_caf_pkg::ST_CORDIC;
      end
      imu_caf_pkg::ST_CORDIC:
        if (cord_done) begin
          if (!tilt_r) begin
            tilt_nxt = 1'b1;
            st_nxt = imu_caf_pkg::ST_ROOT_START;
          end else if (mode_r) begin
            axis_nxt = 2'd0;
            st_nxt = imu_caf_pkg::ST_GYRO_MUL;
          end else begin
            st_nxt = imu_caf_pkg::ST_DONE;
          end
        end
      imu_caf_pkg::ST_GYRO_MUL: begin
        st_nxt = imu_caf_pkg::ST_GYRO_DIV;
        div_ctl.start = 1'b1;
      end
      imu_caf_pkg::ST_GYRO_DIV:
        if (div_done) st_nxt = imu_caf_pkg::ST_BLEND_A;
      imu_caf_pkg::ST_BLEND_A: st_nxt = imu_caf_pkg::ST_BLEND_B;
      imu_caf_pkg::ST_BLEND_B: st_nxt = imu_caf_pkg::ST_BLEND_C;
      imu_caf_pkg::ST_BLEND_C:
        if (axis_r == 2'd2) st_nxt = imu_caf_pkg::ST_DONE;
        else begin
          axis_nxt = axis_r + 2'd1;
          st_nxt = imu_caf_pkg::ST_GYRO_MUL;
        end
      imu_caf_pkg::ST_DONE:
        if (!out_valid_r || out_ready) st_nxt = imu_caf_pkg::ST_IDLE;
      default: st_nxt = imu_caf_pkg::ST_IDLE;
    endcase
  end

  assign in_ready = (st_r == imu_caf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= imu_caf_pkg::ST_IDLE;
      tilt_r <= 1'b0;
      axis_r <= 2'd0;
      out_valid_r <= 1'b0;
      last_roll_r <= '0;
      last_pitch_r <= '0;
      last_yaw_r <= '0;
    end else begin
      st_r <= st_nxt;
      tilt_r <= tilt_nxt;
      axis_r <= axis_nxt;
      if (st_r == imu_caf_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        if (!mode_r) begin
          res_roll_r  <= sat32(54'(tilt_roll_r));
          res_pitch_r <= sat32(54'(tilt_pitch_r));
          res_yaw_r   <= '0;
        end else begin
          res_roll_r  <= last_roll_r;
          res_pitch_r <= last_pitch_r;
          res_yaw_r   <= last_yaw_r;
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // blend result into the state per axis; yaw takes the propagated angle unblended
      if (st_r == imu_caf_pkg::ST_BLEND_C) begin
        unique case (axis_r)
          2'd0:    last_roll_r  <= sat32(shifted);
          2'd1:    last_pitch_r <= sat32(shifted);
          default: last_yaw_r   <= sat32(54'(prop_r));
        endcase
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (st_r == imu_caf_pkg::ST_IDLE && in_valid) begin
      ax_r <= in_accel_x_raw; ay_r <= in_accel_y_raw; az_r <= in_accel_z_raw;
      gz_r <= in_yaw_rate_raw; gx_r <= in_roll_rate_raw; gy_r <= in_pitch_rate_raw;
    end
    if (root_done) root_hold_r <= root_val;
    if (cord_done) begin
      if (!tilt_r) tilt_roll_r <= cord_angle;
      else tilt_pitch_r <= cord_angle;
    end
    if (st_r == imu_caf_pkg::ST_GYRO_MUL) neg_r <= graw[15];
    if (div_done) inc_r <= neg_r ? -34'(quot) : 34'(quot);
    if (st_r == imu_caf_pkg::ST_BLEND_A) prop_r <= 34'(last_sel) + inc_r;
    if (st_r == imu_caf_pkg::ST_BLEND_B) begin
      prod_a_r <= 52'(signed'({1'b0, w_eff})) * 52'(prop_r);
      prod_b_r <= 52'(signed'({1'b0, 16'd32768 - w_eff})) * 52'(acc_sel);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_roll_deg  = res_roll_r;
  assign out_pitch_deg = res_pitch_r;
  assign out_yaw_deg   = res_yaw_r;
endmodule
